@@ rtl/conv3_pkg.sv @@
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared constants, types and helpers of the streaming 3x3x3 convolution.
// ----------------------------------------------------------------------------
package conv3_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_DEPTH  = 4096;

    localparam int N_COEF     = 27;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int CIDX_W     = 5;
    localparam int PROD_W     = 35;
    localparam int SUM_W      = 40;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int PLANE_W    = 12;
    localparam int QDEPTH     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic [N_COEF-1:0][SAMPLE_W-1:0] t_taps;
    typedef logic [N_COEF-1:0][COEF_W-1:0]   t_coefs;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic               last;
    } t_meta;

    typedef struct packed {
        logic  vld;
        t_meta meta;
    } t_win;

    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v < 32'd1) r = 32'd1;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

@@ rtl/conv3_ram.sv @@
// ----------------------------------------------------------------------------
// conv3_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module conv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/conv3_dly.sv @@
// ----------------------------------------------------------------------------
// conv3_dly
// Variable-length sample delay line built on a circular RAM buffer.
// ----------------------------------------------------------------------------
module conv3_dly
    import conv3_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_clr,
    input  logic                                    i_adv,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_last,
    input  logic [WIDTH-1:0]                        i_din,
    output logic [WIDTH-1:0]                        o_dout
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;

    always_comb begin
        n_ptr = r_ptr;
        if (i_clr) begin
            n_ptr = '0;
        end else if (i_adv) begin
            n_ptr = (r_ptr == i_last) ? '0 : r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    conv3_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_adv),
        .i_waddr (r_ptr),
        .i_wdata (i_din),
        .i_re    (i_adv),
        .i_raddr (r_ptr),
        .o_rdata (o_dout)
    );

endmodule

@@ rtl/conv3_front.sv @@
// ----------------------------------------------------------------------------
// conv3_front
// Accepts items, loads coefficients, tracks the padded position and forms
// the 27-sample window from plane and row delay lines.
// ----------------------------------------------------------------------------
module conv3_front
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_opcode,
    input  logic [CIDX_W-1:0]       i_coeff_index,
    input  logic signed [COEF_W-1:0] i_coeff_value,
    input  logic [SAMPLE_W-1:0]     i_sample,
    input  logic                    i_space,
    output logic                    o_commit,
    output t_win                    o_win,
    output t_taps                   o_taps,
    output t_coefs                  o_coefs
);

    localparam int CW     = $clog2(MAX_WIDTH + 2);
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int PW     = $clog2(MAX_DEPTH + 2);
    localparam int EWW    = $clog2(MAX_WIDTH + 1);
    localparam int EHW    = $clog2(MAX_HEIGHT + 1);
    localparam int EDW    = $clog2(MAX_DEPTH + 1);
    localparam int RDEPTH = MAX_WIDTH + 1;
    localparam int RAW    = $clog2(RDEPTH);
    localparam int PDEPTH = (MAX_WIDTH + 2) * (MAX_HEIGHT + 2) - 1;
    localparam int PAW    = $clog2(PDEPTH);

    logic [EWW-1:0] r_effw, n_effw;
    logic [EHW-1:0] r_effh, n_effh;
    logic [EDW-1:0] r_effd, n_effd;
    logic [PAW-1:0] r_plast;
    logic           cfg_hit;

    logic [CW-1:0]  r_c;
    logic [RW-1:0]  r_r;
    logic [PW-1:0]  r_p;
    logic [CW-1:0]  cmax;
    logic [RW-1:0]  rmax;
    logic [PW-1:0]  pmax;

    logic           acc;
    logic           adv;
    logic           produce;

    logic [SAMPLE_W-1:0] r_x;
    logic [SAMPLE_W-1:0] z [3];
    logic [SAMPLE_W-1:0] strm [3][3];
    logic [SAMPLE_W-1:0] r_d1 [3][3];
    logic [SAMPLE_W-1:0] r_d2 [3][3];

    t_coefs r_coef;
    t_win   r_win;

    always_comb begin
        n_effw  = r_effw;
        n_effh  = r_effh;
        n_effd  = r_effd;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH: begin
                    n_effw  = EWW'(clamp_size(32'(i_cfg_data[8:0]), 32'(MAX_WIDTH)));
                    cfg_hit = 1'b1;
                end
                REG_HEIGHT: begin
                    n_effh  = EHW'(clamp_size(32'(i_cfg_data[8:0]), 32'(MAX_HEIGHT)));
                    cfg_hit = 1'b1;
                end
                REG_DEPTH: begin
                    n_effd  = EDW'(clamp_size(32'(i_cfg_data[12:0]), 32'(MAX_DEPTH)));
                    cfg_hit = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effw  <= EWW'(clamp_size(32'd256, 32'(MAX_WIDTH)));
            r_effh  <= EHW'(clamp_size(32'd128, 32'(MAX_HEIGHT)));
            r_effd  <= EDW'(clamp_size(32'd128, 32'(MAX_DEPTH)));
            r_plast <= PAW'((clamp_size(32'd256, 32'(MAX_WIDTH)) + 32'd2)
                          * (clamp_size(32'd128, 32'(MAX_HEIGHT)) + 32'd2) - 32'd2);
        end else if (cfg_hit) begin
            r_effw  <= n_effw;
            r_effh  <= n_effh;
            r_effd  <= n_effd;
            r_plast <= PAW'((32'(n_effw) + 32'd2) * (32'(n_effh) + 32'd2) - 32'd2);
        end
    end

    assign cmax    = CW'(r_effw) + CW'(1);
    assign rmax    = RW'(r_effh) + RW'(1);
    assign pmax    = PW'(r_effd) + PW'(1);

    assign o_ready = i_space;
    assign acc     = i_valid && o_ready;
    assign adv     = acc && (i_opcode == OP_SAMPLE);
    assign produce = (32'(r_c) >= 32'd2) && (32'(r_r) >= 32'd2) && (32'(r_p) >= 32'd2);
    assign o_commit = adv && produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
            r_r <= '0;
            r_p <= '0;
        end else if (cfg_hit) begin
            r_c <= '0;
            r_r <= '0;
            r_p <= '0;
        end else if (adv) begin
            if (r_c == cmax) begin
                r_c <= '0;
                if (r_r == rmax) begin
                    r_r <= '0;
                    r_p <= (r_p == pmax) ? '0 : r_p + PW'(1);
                end else begin
                    r_r <= r_r + RW'(1);
                end
            end else begin
                r_c <= r_c + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && (i_opcode == OP_COEF) && (32'(i_coeff_index) < 32'(N_COEF))) begin
            r_coef[i_coeff_index] <= i_coeff_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.vld <= 1'b0;
        end else begin
            r_win.vld <= adv && produce;
        end
        if (adv) begin
            r_win.meta.col   <= COL_W'(32'(r_c) - 32'd2);
            r_win.meta.row   <= ROW_W'(32'(r_r) - 32'd2);
            r_win.meta.plane <= PLANE_W'(32'(r_p) - 32'd2);
            r_win.meta.last  <= (r_c == cmax) && (r_r == rmax) && (r_p == pmax);
            r_x  <= i_sample;
            r_d1 <= strm;
            r_d2 <= r_d1;
        end
    end

    assign z[2] = r_x;

    conv3_dly #(.WIDTH(SAMPLE_W), .DEPTH(PDEPTH)) u_plane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cfg_hit),
        .i_adv   (adv),
        .i_last  (r_plast),
        .i_din   (z[2]),
        .o_dout  (z[1])
    );

    conv3_dly #(.WIDTH(SAMPLE_W), .DEPTH(PDEPTH)) u_plane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cfg_hit),
        .i_adv   (adv),
        .i_last  (r_plast),
        .i_din   (z[1]),
        .o_dout  (z[0])
    );

    for (genvar g = 0; g < 3; g++) begin : g_rows
        assign strm[g][2] = z[g];

        conv3_dly #(.WIDTH(SAMPLE_W), .DEPTH(RDEPTH)) u_row_1 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (cfg_hit),
            .i_adv   (adv),
            .i_last  (RAW'(r_effw)),
            .i_din   (strm[g][2]),
            .o_dout  (strm[g][1])
        );

        conv3_dly #(.WIDTH(SAMPLE_W), .DEPTH(RDEPTH)) u_row_0 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (cfg_hit),
            .i_adv   (adv),
            .i_last  (RAW'(r_effw)),
            .i_din   (strm[g][1]),
            .o_dout  (strm[g][0])
        );
    end

    always_comb begin
        o_taps = '0;
        for (int kz = 0; kz < 3; kz++) begin
            for (int ky = 0; ky < 3; ky++) begin
                o_taps[kz * 9 + ky * 3 + 2] = strm[kz][ky];
                o_taps[kz * 9 + ky * 3 + 1] = r_d1[kz][ky];
                o_taps[kz * 9 + ky * 3]     = r_d2[kz][ky];
            end
        end
    end

    assign o_win   = r_win;
    assign o_coefs = r_coef;

endmodule

@@ rtl/conv3_back.sv @@
// ----------------------------------------------------------------------------
// conv3_back
// Multiplies the window by the coefficients, sums through a registered
// tree and queues finished voxels for the output channel.
// ----------------------------------------------------------------------------
module conv3_back
    import conv3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_win                     i_win,
    input  t_taps                    i_taps,
    input  t_coefs                   i_coefs,
    input  logic                     i_commit,
    output logic                     o_space,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [SUM_W-1:0]  o_sum,
    output t_meta                    o_meta
);

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    logic signed [PROD_W-1:0] r_prod [N_COEF];
    logic signed [SUM_W-1:0]  r_s2 [9];
    logic signed [SUM_W-1:0]  r_s3 [3];
    logic                     r_v1, r_v2, r_v3;
    t_meta                    r_m1, r_m2, r_m3;

    logic signed [SUM_W-1:0]  r_qsum [QDEPTH];
    t_meta                    r_qmeta [QDEPTH];
    logic [QAW-1:0]           r_wp;
    logic [QAW-1:0]           r_rp;
    logic [QCW-1:0]           r_qcnt;
    logic [QCW-1:0]           r_occ;
    logic                     pop;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_COEF; i++) begin
            r_prod[i] <= $signed(i_coefs[i]) * $signed({1'b0, i_taps[i]});
        end
        for (int j = 0; j < 9; j++) begin
            r_s2[j] <= SUM_W'(r_prod[3 * j]) + SUM_W'(r_prod[3 * j + 1])
                     + SUM_W'(r_prod[3 * j + 2]);
        end
        for (int k = 0; k < 3; k++) begin
            r_s3[k] <= r_s2[3 * k] + r_s2[3 * k + 1] + r_s2[3 * k + 2];
        end
        r_m1 <= i_win.meta;
        r_m2 <= r_m1;
        r_m3 <= r_m2;
        if (r_v3) begin
            r_qsum[r_wp]  <= r_s3[0] + r_s3[1] + r_s3[2];
            r_qmeta[r_wp] <= r_m3;
        end
    end

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
            r_occ  <= '0;
        end else begin
            r_v1 <= i_win.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_qcnt <= r_qcnt + QCW'(r_v3) - QCW'(pop);
            r_occ  <= r_occ + QCW'(i_commit) - QCW'(pop);
        end
    end

    assign o_space = (32'(r_occ) < 32'(QDEPTH));
    assign o_valid = (r_qcnt != '0);
    assign o_sum   = r_qsum[r_rp];
    assign o_meta  = r_qmeta[r_rp];

endmodule

@@ rtl/conv3d_3x3x3_stream.sv @@
// ----------------------------------------------------------------------------
// conv3d_3x3x3_stream
// Streaming 3x3x3 convolution over a zero-padded volume.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, coefficient loads and samples
// alike, and passes each output voxel from the window register through the
// product and adder registers into an eight-entry output queue; the
// input ready drops while eight voxels are in the pipeline or the queue. The
// window comes from two plane delay lines of
// (MAX_WIDTH+2)*(MAX_HEIGHT+2)-1 samples and six row delay lines of
// MAX_WIDTH+1 samples, each a RAM read and written once per sample; their
// contents need no clearing after reset and there is no start-up pass.
// A register write restarts the volume at its first padded sample.
module conv3d_3x3x3_stream
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_opcode,
    input  logic [CIDX_W-1:0]        i_coeff_index,
    input  logic signed [COEF_W-1:0] i_coeff_value,
    input  logic [SAMPLE_W-1:0]      i_sample,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [SUM_W-1:0]  o_conv_sum,
    output logic [COL_W-1:0]         o_out_col,
    output logic [ROW_W-1:0]         o_out_row,
    output logic [PLANE_W-1:0]       o_out_plane,
    output logic                     o_last_voxel
);

    logic   space;
    logic   commit;
    t_win   win;
    t_taps  taps;
    t_coefs coefs;
    t_meta  meta;

    conv3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_sample      (i_sample),
        .i_space       (space),
        .o_commit      (commit),
        .o_win         (win),
        .o_taps        (taps),
        .o_coefs       (coefs)
    );

    conv3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (win),
        .i_taps   (taps),
        .i_coefs  (coefs),
        .i_commit (commit),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_sum    (o_conv_sum),
        .o_meta   (meta)
    );

    assign o_out_col    = meta.col;
    assign o_out_row    = meta.row;
    assign o_out_plane  = meta.plane;
    assign o_last_voxel = meta.last;

endmodule

@@ test/conv3d_3x3x3_stream_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3d_3x3x3_stream_chk
// Watches both item channels and the register port of the 3x3x3 convolution,
// keeps its own copy of coefficients, sample history and volume position,
// predicts each output voxel and compares it field by field in order.
// ----------------------------------------------------------------------------
module conv3d_3x3x3_stream_chk
    import conv3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    input  logic                     i_in_ready,
    input  logic                     i_opcode,
    input  logic [CIDX_W-1:0]        i_coeff_index,
    input  logic signed [COEF_W-1:0] i_coeff_value,
    input  logic [SAMPLE_W-1:0]      i_sample,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [SUM_W-1:0]  i_conv_sum,
    input  logic [COL_W-1:0]         i_out_col,
    input  logic [ROW_W-1:0]         i_out_row,
    input  logic [PLANE_W-1:0]       i_out_plane,
    input  logic                     i_last_voxel,
    output int                       o_errors,
    output int                       o_pending
);

    localparam int RING_LEN = 2 * (DEF_MAX_WIDTH + 2) * (DEF_MAX_HEIGHT + 2)
                            + 2 * (DEF_MAX_WIDTH + 2) + 3;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic [PLANE_W-1:0]      plane;
        logic                    last;
    } t_voxel;

    t_voxel                  voxel_q[$];
    logic signed [COEF_W-1:0] coef_store[N_COEF];
    logic [SAMPLE_W-1:0]     sample_ring[RING_LEN];
    int                      ring_wp;
    int                      reg_w, reg_h, reg_d;
    int                      pos_c, pos_r, pos_p;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int clip(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    task automatic advance_volume(logic [SAMPLE_W-1:0] smp);
        int     pw, ph, pd, dly;
        longint acc;
        t_voxel vx;
        pw = clip(reg_w, DEF_MAX_WIDTH) + 2;
        ph = clip(reg_h, DEF_MAX_HEIGHT) + 2;
        pd = clip(reg_d, DEF_MAX_DEPTH) + 2;
        ring_wp = (ring_wp + 1) % RING_LEN;
        sample_ring[ring_wp] = smp;
        if (pos_c >= 2 && pos_r >= 2 && pos_p >= 2) begin
            acc = 0;
            for (int kz = 0; kz < 3; kz++)
                for (int ky = 0; ky < 3; ky++)
                    for (int kx = 0; kx < 3; kx++) begin
                        dly = (2 - kz) * pw * ph + (2 - ky) * pw + (2 - kx);
                        acc += longint'(coef_store[kz * 9 + ky * 3 + kx])
                             * longint'({1'b0, sample_ring[(ring_wp + RING_LEN - dly) % RING_LEN]});
                    end
            vx.sum   = acc[SUM_W-1:0];
            vx.col   = COL_W'(pos_c - 2);
            vx.row   = ROW_W'(pos_r - 2);
            vx.plane = PLANE_W'(pos_p - 2);
            vx.last  = (pos_c == pw - 1 && pos_r == ph - 1 && pos_p == pd - 1);
            voxel_q.push_back(vx);
        end
        pos_c++;
        if (pos_c >= pw) begin
            pos_c = 0;
            pos_r++;
            if (pos_r >= ph) begin
                pos_r = 0;
                pos_p++;
                if (pos_p >= pd) pos_p = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_voxel vx;
        if (!i_rst_n) begin
            reg_w = 256;
            reg_h = 128;
            reg_d = 128;
            ring_wp = 0;
            pos_c = 0;
            pos_r = 0;
            pos_p = 0;
            voxel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  reg_w = i_cfg_data & 13'h1FF;
                    REG_HEIGHT: reg_h = i_cfg_data & 13'h1FF;
                    REG_DEPTH:  reg_d = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_idx inside {REG_WIDTH, REG_HEIGHT, REG_DEPTH}) begin
                    pos_c = 0;
                    pos_r = 0;
                    pos_p = 0;
                end
            end
            if (i_valid && i_in_ready) begin
                if (i_opcode == OP_COEF) begin
                    if (i_coeff_index < N_COEF) coef_store[i_coeff_index] = i_coeff_value;
                end else begin
                    advance_volume(i_sample);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (voxel_q.size() == 0) begin
                    $display("%0t: output voxel with none expected", $time);
                    o_errors++;
                end else begin
                    vx = voxel_q.pop_front();
                    if (i_conv_sum !== vx.sum) report("conv_sum", i_conv_sum, vx.sum);
                    if (i_out_col !== vx.col) report("out_col", i_out_col, vx.col);
                    if (i_out_row !== vx.row) report("out_row", i_out_row, vx.row);
                    if (i_out_plane !== vx.plane) report("out_plane", i_out_plane, vx.plane);
                    if (i_last_voxel !== vx.last) report("last_voxel", i_last_voxel, vx.last);
                end
            end
        end
        o_pending = voxel_q.size();
    end

endmodule

@@ test/conv3d_3x3x3_stream_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3d_3x3x3_stream_tb
// Drives coefficient loads and padded volumes of many sizes into the 3x3x3
// convolution with random gaps and output stalls; the checker beside the
// block predicts and compares every output voxel.
// ----------------------------------------------------------------------------
module conv3d_3x3x3_stream_tb;
    import conv3_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_opcode;
    logic [CIDX_W-1:0]        i_coeff_index;
    logic signed [COEF_W-1:0] i_coeff_value;
    logic [SAMPLE_W-1:0]      i_sample;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [SUM_W-1:0]  o_conv_sum;
    logic [COL_W-1:0]         o_out_col;
    logic [ROW_W-1:0]         o_out_row;
    logic [PLANE_W-1:0]       o_out_plane;
    logic                     o_last_voxel;
    int                       fail_count;
    int                       pending;
    int                       rdy_hold;
    int                       item_count;

    conv3d_3x3x3_stream uut (.*);

    conv3d_3x3x3_stream_chk chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid,
        .i_in_ready(o_ready), .i_opcode, .i_coeff_index, .i_coeff_value, .i_sample,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_conv_sum(o_conv_sum),
        .i_out_col(o_out_col), .i_out_row(o_out_row), .i_out_plane(o_out_plane),
        .i_last_voxel(o_last_voxel), .o_errors(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if ($urandom_range(0, 99) < 65) begin
            i_ready  <= 1'b1;
            rdy_hold <= $urandom_range(1, 40);
        end else begin
            i_ready  <= 1'b0;
            rdy_hold <= idle_len();
        end
    end

    task automatic send(logic op, logic [CIDX_W-1:0] cidx, logic [COEF_W-1:0] cval,
                        logic [SAMPLE_W-1:0] smp, bit gaps);
        int g;
        g = gaps ? idle_len() : 0;
        @(negedge i_clk);
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_opcode      = op;
        i_coeff_index = cidx;
        i_coeff_value = cval;
        i_sample      = smp;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        item_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_volume(int w, int h, int d);
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_DEPTH, CFG_DATA_W'(d));
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 18'h1FFFF;
        if (r == 1) return 18'h20000;
        return COEF_W'($urandom);
    endfunction

    task automatic stream_samples(int count, bit gaps);
        for (int n = 0; n < count; n++) begin
            if (gaps && $urandom_range(0, 19) == 0)
                send(OP_COEF, CIDX_W'($urandom), rand_coef(), SAMPLE_W'($urandom), gaps);
            send(OP_SAMPLE, CIDX_W'($urandom), COEF_W'($urandom), rand_sample(), gaps);
        end
    endtask

    initial begin
        int w, h, d, full, sel;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_opcode = OP_COEF;
        i_coeff_index = '0;
        i_coeff_value = '0;
        i_sample = '0;
        rdy_hold = 0;
        item_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Smallest volume with extreme coefficients, then ignored loads, then extreme samples.
        set_volume(1, 1, 1);
        for (int k = 0; k < N_COEF; k++)
            send(OP_COEF, CIDX_W'(k), (k % 2) ? 18'h20000 : 18'h1FFFF, '0, 1'b0);
        send(OP_COEF, 5'd27, 18'h00001, '1, 1'b0);
        send(OP_COEF, 5'd31, 18'h3FFFF, '1, 1'b0);
        for (int n = 0; n < 27; n++) send(OP_SAMPLE, '0, '0, (n % 2) ? '0 : '1, 1'b1);
        for (int n = 0; n < 27; n++) send(OP_SAMPLE, '1, '1, '1, 1'b1);

        // Clamped sizes: zero sizes, the largest sizes and depths beyond the maximum.
        set_volume(0, 0, 0);
        stream_samples(27 * 2, 1'b1);
        set_volume(0, 511, 1);
        stream_samples(40, 1'b1);
        set_volume(256, 1, 0);
        stream_samples(40, 1'b1);
        set_volume(1, 1, 4096);
        stream_samples(3 * 3 * 8, 1'b1);
        set_volume(1, 1, 8191);
        stream_samples(3 * 3 * 5, 1'b1);

        while (item_count < 600) begin
            sel = $urandom_range(0, 19);
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 4);
            d = $urandom_range(1, 3);
            if (sel == 0) w = 300 + $urandom_range(0, 211);
            if (sel == 1) h = 0;
            set_volume(w, h, d);
            for (int k = 0; k < N_COEF; k++)
                if ($urandom_range(0, 2) == 0)
                    send(OP_COEF, CIDX_W'(k), rand_coef(), SAMPLE_W'($urandom), 1'b1);
            if (h < 1) h = 1;
            if (w > 256) begin
                stream_samples($urandom_range(1, 60), 1'b1);
            end else begin
                full = (w + 2) * (h + 2) * (d + 2);
                sel = $urandom_range(0, 3);
                if (sel == 0) stream_samples($urandom_range(1, full), sel[0]);
                else stream_samples(full * $urandom_range(1, 2), $urandom_range(0, 4) != 0);
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
